>>> rtl/jass_pkg.sv
// Shared types and constants for the movie byte-stream segmenter.
// No dependencies; imported by every module of the block.
package jass_pkg;

  localparam int SEG_W     = 48;
  localparam int CFG_W     = 16;
  localparam int DIG_W     = 8;
  localparam int DIV_STEPS = SEG_W / DIG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int REM_W     = 3;

  localparam logic [23:0]      TAG_JFI     = 24'h4A4649;
  localparam logic [7:0]       CHAR_F      = 8'h46;
  localparam logic [7:0]       MARK_FF     = 8'hFF;
  localparam logic [7:0]       MARK_D9     = 8'hD9;
  localparam logic [SEG_W-1:0] TAG_LEAD    = SEG_W'(9);
  localparam logic [CFG_W-1:0] AUDIO_RESET = CFG_W'(16'h0010);

  localparam logic [REM_W:0]   FRAME_BYTES = 4'd6;
  // x / 3 == (x * 683) >> 11 for every 10-bit x
  localparam logic [9:0]       RECIP3      = 10'd683;
  localparam int               RECIP_SH    = 11;

  localparam logic KIND_AUDIO = 1'b0;
  localparam logic KIND_VIDEO = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [SEG_W-1:0] start;
    logic [SEG_W-1:0] len;
  } seg_ev_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_DIV
  } bk_state_t;

endpackage

>>> rtl/jass_front.sv
// Front end: accepts bytes, tracks position and tag matches, emits segment events.
// Depends on jass_pkg.
module jass_front
  import jass_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_push,
  input  logic [7:0]       in_data_byte,
  input  logic             q_full,
  output logic             ev_push,
  output seg_ev_t          ev
);

  logic [SEG_W-1:0] pos_r, pos_nxt;
  logic [SEG_W-1:0] cand_r, cand_nxt;
  logic             lo_r, lo_nxt;
  logic [23:0]      win_r, win_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             inpic_r, inpic_nxt;
  logic [SEG_W-1:0] audio_r, audio_nxt;
  logic [SEG_W-1:0] pic_r, pic_nxt;

  logic             accept;
  logic [SEG_W-1:0] start;
  logic [SEG_W:0]   diff;
  logic             gap;
  logic [SEG_W-1:0] end_pos;
  logic             tag_hit;
  logic             eoi_hit;

  assign accept  = in_push && !q_full;
  assign start   = lo_r ? '0 : cand_r;
  assign diff    = {1'b0, start} - {1'b0, audio_r};
  assign gap     = !diff[SEG_W] && (diff[SEG_W-1:0] != '0);
  assign end_pos = pos_r + SEG_W'(1);
  assign tag_hit = !inpic_r && (fill_r == 2'd3) && (win_r == TAG_JFI) &&
                   (in_data_byte == CHAR_F);
  assign eoi_hit = inpic_r && (fill_r != 2'd0) && (win_r[7:0] == MARK_FF) &&
                   (in_data_byte == MARK_D9);

  always_comb begin
    pos_nxt   = pos_r;
    cand_nxt  = cand_r;
    lo_nxt    = lo_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    inpic_nxt = inpic_r;
    audio_nxt = audio_r;
    pic_nxt   = pic_r;
    ev_push   = 1'b0;
    ev.kind   = KIND_AUDIO;
    ev.start  = audio_r;
    ev.len    = diff[SEG_W-1:0];
    if (accept) begin
      pos_nxt  = end_pos;
      cand_nxt = cand_r + SEG_W'(1);
      if (end_pos == TAG_LEAD) begin
        lo_nxt = 1'b0;
      end else if (end_pos == '0) begin
        lo_nxt = 1'b1;
      end
      if (tag_hit) begin
        if (gap) begin
          ev_push   = 1'b1;
          audio_nxt = start;
        end
        pic_nxt   = start;
        inpic_nxt = 1'b1;
        win_nxt   = '0;
        fill_nxt  = '0;
      end else if (eoi_hit) begin
        ev_push   = 1'b1;
        ev.kind   = KIND_VIDEO;
        ev.start  = pic_r;
        ev.len    = end_pos - pic_r;
        audio_nxt = end_pos;
        inpic_nxt = 1'b0;
        win_nxt   = '0;
        fill_nxt  = '0;
      end else begin
        win_nxt = {win_r[15:0], in_data_byte};
        if (fill_r != 2'd3) begin
          fill_nxt = fill_r + 2'd1;
        end
      end
    end
    if (cfg_wr_en) begin
      audio_nxt = SEG_W'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      cand_r  <= '0 - TAG_LEAD;
      lo_r    <= 1'b1;
      win_r   <= '0;
      fill_r  <= '0;
      inpic_r <= 1'b0;
      audio_r <= SEG_W'(AUDIO_RESET);
      pic_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
      lo_r    <= lo_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      inpic_r <= inpic_nxt;
      audio_r <= audio_nxt;
      pic_r   <= pic_nxt;
    end
  end

endmodule

>>> rtl/jass_queue.sv
// Four-entry event queue between the front end and the back end.
// Depends on jass_pkg.
module jass_queue
  import jass_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  seg_ev_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output logic    empty,
  output seg_ev_t rd_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  seg_ev_t          mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == (PTR_W + 1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + PTR_W'(1) : wptr_r;
    rptr_nxt = do_rd ? rptr_r + PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (PTR_W + 1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> rtl/jass_back.sv
// Back end: turns queued events into results; audio lengths are divided by
// the frame size one byte digit per cycle. Depends on jass_pkg.
module jass_back
  import jass_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  seg_ev_t          q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic             out_segment_kind,
  output logic [SEG_W-1:0] out_segment_start,
  output logic [SEG_W-1:0] out_segment_length,
  output logic [SEG_W-1:0] out_unit_count
);

  bk_state_t         state_r, state_nxt;
  logic              ovld_r, ovld_nxt;
  logic              okind_r;
  logic [SEG_W-1:0]  ostart_r;
  logic [SEG_W-1:0]  olen_r;
  logic [SEG_W-1:0]  ounits_r;
  logic [SEG_W-1:0]  dstart_r;
  logic [SEG_W-1:0]  dlen_r;
  logic [SEG_W-1:0]  dvd_r;
  logic [SEG_W-1:0]  quo_r;
  logic [REM_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic                   slot_free;
  logic                   div_done;
  logic [REM_W+DIG_W-1:0] t;
  logic [9:0]             x;
  logic [19:0]            prod;
  logic [DIG_W-1:0]       qd;
  logic [REM_W+DIG_W-1:0] rfull;
  logic                   load_video;
  logic                   load_audio;
  logic                   write_audio;

  assign slot_free = !ovld_r || pop;
  assign div_done  = (step_r == STEP_W'(DIV_STEPS));
  assign t         = {rem_r, dvd_r[SEG_W-1 -: DIG_W]};
  assign x         = t[REM_W+DIG_W-1:1];
  assign prod      = 20'(x) * 20'(RECIP3);
  assign qd        = prod[RECIP_SH +: DIG_W];
  assign rfull     = t - (REM_W + DIG_W)'(qd) * (REM_W + DIG_W)'(FRAME_BYTES);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && q_data.kind == KIND_AUDIO) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done && slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load_video  = 1'b0;
    load_audio  = 1'b0;
    write_audio = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.kind == KIND_VIDEO) begin
            load_video = slot_free;
          end else begin
            load_audio = 1'b1;
          end
        end
      end
      BK_DIV: begin
        write_audio = div_done && slot_free;
      end
      default: ;
    endcase
    q_pop    = load_video || load_audio;
    step_nxt = load_audio ? '0 : (div_done ? step_r : step_r + STEP_W'(1));
    ovld_nxt = (load_video || write_audio) ? 1'b1 : (pop ? 1'b0 : ovld_r);
  end

  always_ff @(posedge clk) begin
    if (load_audio) begin
      dstart_r <= q_data.start;
      dlen_r   <= q_data.len;
      dvd_r    <= q_data.len;
      quo_r    <= '0;
      rem_r    <= '0;
    end else if (state_r == BK_DIV && !div_done) begin
      dvd_r <= dvd_r << DIG_W;
      quo_r <= {quo_r[SEG_W-DIG_W-1:0], qd};
      rem_r <= rfull[REM_W-1:0];
    end
    if (load_video) begin
      okind_r  <= KIND_VIDEO;
      ostart_r <= q_data.start;
      olen_r   <= q_data.len;
      ounits_r <= SEG_W'(1);
    end else if (write_audio) begin
      okind_r  <= KIND_AUDIO;
      ostart_r <= dstart_r;
      olen_r   <= dlen_r;
      ounits_r <= quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ovld_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      step_r  <= step_nxt;
    end
  end

  assign empty              = !ovld_r;
  assign out_segment_kind   = okind_r;
  assign out_segment_start  = ostart_r;
  assign out_segment_length = olen_r;
  assign out_unit_count     = ounits_r;

endmodule

>>> rtl/jpeg_audio_stream_segmenter.sv
// Top level of the movie byte-stream segmenter.
// Instantiates jass_front, jass_queue and jass_back; depends on jass_pkg.
//
// Usage:
//   Input channel: drive in_data_byte and push; a byte is taken on a clock
//   edge with push high and full low; one byte per cycle while not full.
//   Result channel: while empty is low the oldest segment is on the out_
//   ports; pop high on an edge takes it.
//   Configuration: cfg_wr_en loads cfg_wr_data as the start of the first
//   audio region; write only while the block is idle.
//   Result path: a JPEG event, pushed on its D9 byte, goes through the
//   queue to the output register. An audio event is pushed on its tag byte;
//   the back end divides the length by the frame size one digit per cycle.
//   Audio results come at least 10 bytes apart, so the back end keeps up
//   with a full-rate input stream.
//   Stalls: results wait in a one-entry output register, events in a
//   four-entry queue; full rises only when that queue is full.
//   Reset (rst_n low, synchronous): position, match window and mode clear,
//   the audio start returns to 16, queued events and results are dropped.
module jpeg_audio_stream_segmenter
  import jass_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_data_byte,
  output logic             empty,
  input  logic             pop,
  output logic             out_segment_kind,
  output logic [SEG_W-1:0] out_segment_start,
  output logic [SEG_W-1:0] out_segment_length,
  output logic [SEG_W-1:0] out_unit_count
);

  logic    ev_push;
  seg_ev_t ev;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  seg_ev_t q_data;

  assign full = q_full;

  jass_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_push      (push),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .ev_push      (ev_push),
    .ev           (ev)
  );

  jass_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ev_push),
    .wr_data (ev),
    .full    (q_full),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  jass_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .out_segment_kind   (out_segment_kind),
    .out_segment_start  (out_segment_start),
    .out_segment_length (out_segment_length),
    .out_unit_count     (out_unit_count)
  );

endmodule
